// File: sv/cvm_pkg.sv
// Shared types, constants and verb/flag tables for the control verb matcher.
package cvm_pkg;

    // Verb table size and the length of the json option text
    localparam int VERB_COUNT = 7;
    localparam int FLAG_LEN   = 6;

    // Highest valid command code
    localparam logic [2:0] CODE_LAST = 3'(VERB_COUNT - 1);

    // Parse phase codes
    localparam logic [1:0] PH_LEAD  = 2'd0;
    localparam logic [1:0] PH_WORD  = 2'd1;
    localparam logic [1:0] PH_AFTER = 2'd2;

    // Byte codes of interest
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_DASH  = 8'h2D;

    // Word byte counter saturation value
    localparam logic [3:0] COUNT_MAX = 4'd15;

    // One result item
    typedef struct packed {
        logic       matched;
        logic [2:0] command_code;
        logic       json_flag;
    } t_result;

    // Character idx of verb v; positions past the end read as NUL
    function automatic logic [7:0] verb_char(input logic [2:0] v, input logic [2:0] idx);
        logic [55:0] text;
        begin
            case (v)
                3'd0:    text = {"start", 16'h0};
                3'd1:    text = {"stop", 24'h0};
                3'd2:    text = {"toggle", 8'h0};
                3'd3:    text = "dictate";
                3'd4:    text = {"cancel", 8'h0};
                3'd5:    text = {"status", 8'h0};
                3'd6:    text = {"reload", 8'h0};
                default: text = '0;
            endcase
            if (idx == 3'd7) begin
                verb_char = 8'h00;
            end else begin
                verb_char = text[8'(55 - 8 * int'(idx)) -: 8];
            end
        end
    endfunction

    // Length of verb v
    function automatic logic [3:0] verb_len(input logic [2:0] v);
        begin
            case (v)
                3'd0:    verb_len = 4'd5;
                3'd1:    verb_len = 4'd4;
                3'd2:    verb_len = 4'd6;
                3'd3:    verb_len = 4'd7;
                3'd4:    verb_len = 4'd6;
                3'd5:    verb_len = 4'd6;
                3'd6:    verb_len = 4'd6;
                default: verb_len = 4'd0;
            endcase
        end
    endfunction

    // Expected character at each position of "--json"
    function automatic logic [7:0] flag_char(input logic [2:0] pos);
        begin
            case (pos)
                3'd0:    flag_char = "-";
                3'd1:    flag_char = "-";
                3'd2:    flag_char = "j";
                3'd3:    flag_char = "s";
                3'd4:    flag_char = "o";
                3'd5:    flag_char = "n";
                default: flag_char = 8'h00;
            endcase
        end
    endfunction

endpackage

// File: sv/cvm_in_if.sv
// Message byte channel: one byte per transfer with a last-byte mark.
interface cvm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       last_byte;

    modport source (output valid, output char_byte, output last_byte, input ready);
    modport sink   (input valid, input char_byte, input last_byte, output ready);
endinterface

// File: sv/cvm_out_if.sv
// Result channel: match flag, command code and json flag per transfer.
interface cvm_out_if;
    logic       valid;
    logic       ready;
    logic       matched;
    logic [2:0] command_code;
    logic       json_flag;

    modport source (output valid, output matched, output command_code, output json_flag,
                    input ready);
    modport sink   (input valid, input matched, input command_code, input json_flag,
                    output ready);
endinterface

// File: sv/control_verb_matcher.sv
// Top level: input byte register, parser and result output register.
// The last byte of a message waits in the input register until the output register is free,
// then its result loads the output register and is shown there as valid.
// Throughput: one byte per cycle; a last byte stalls while the previous result waits untaken.
// Reset (synchronous, active low) empties both registers and returns the parser to the
// leading-whitespace phase with all verbs live.
module control_verb_matcher
    import cvm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    cvm_in_if.sink    i_msg,
    cvm_out_if.source o_res
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_out;

    logic       out_free, step;
    t_result    result;

    // A byte moves through the parser unless its result would have nowhere to go
    assign out_free    = !r_out_valid || o_res.ready;
    assign step        = r_in_valid && (!r_in_last || out_free);
    assign i_msg.ready = !r_in_valid || step;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_msg.ready) begin
            r_in_valid <= i_msg.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_msg.valid && i_msg.ready) begin
            r_in_byte <= i_msg.char_byte;
            r_in_last <= i_msg.last_byte;
        end
    end

    cvm_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_char   (r_in_byte),
        .i_last   (r_in_last),
        .o_result (result)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in_last) begin
            r_out <= result;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.matched      = r_out.matched;
    assign o_res.command_code = r_out.command_code;
    assign o_res.json_flag    = r_out.json_flag;

endmodule

// File: sv/cvm_parser.sv
// Per-byte parse state, parallel verb compare and json option tracker.
module cvm_parser
    import cvm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_char,
    input  logic       i_last,
    output t_result    o_result
);

    logic [1:0]            r_phase, n_phase;
    logic [VERB_COUNT-1:0] r_alive, n_alive;
    logic [3:0]            r_count, n_count;
    logic                  r_pend, n_pend;
    logic [2:0]            r_prog, n_prog;
    logic                  r_seen, n_seen;

    logic                  is_sp, is_tab, is_crlf, is_ws, take;
    logic [VERB_COUNT-1:0] char_ok;
    logic [2:0]            prog_step;

    assign is_sp   = (i_char == CH_SPACE);
    assign is_tab  = (i_char == CH_TAB);
    assign is_crlf = (i_char == CH_CR) || (i_char == CH_LF);
    assign is_ws   = is_sp || is_tab || is_crlf;

    // All seven verbs compared against the current word position at once
    always_comb begin
        for (int i = 0; i < VERB_COUNT; i++) begin
            char_ok[i] = (r_count < verb_len(3'(i))) &&
                         (verb_char(3'(i), r_count[2:0]) == i_char);
        end
    end

    // "--json" prefix tracker, restarting on a dash
    always_comb begin
        if ((r_prog < 3'(FLAG_LEN)) && (flag_char(r_prog) == i_char)) begin
            prog_step = r_prog + 3'd1;
        end else if (i_char == CH_DASH) begin
            prog_step = (r_prog == 3'd2) ? 3'd2 : 3'd1;
        end else begin
            prog_step = 3'd0;
        end
    end

    // Next state for one byte
    always_comb begin
        n_phase = r_phase;
        n_alive = r_alive;
        n_count = r_count;
        n_pend  = r_pend;
        n_prog  = r_prog;
        n_seen  = r_seen;
        take    = 1'b0;
        case (r_phase)
            PH_LEAD: begin
                if (!is_sp && !is_tab) begin
                    n_phase = PH_WORD;
                    if (is_crlf) begin
                        n_pend = 1'b1;
                    end else begin
                        take = 1'b1;
                    end
                end
            end
            PH_WORD: begin
                if (is_sp) begin
                    n_phase = PH_AFTER;
                end else if (is_tab || is_crlf) begin
                    n_pend = 1'b1;
                end else begin
                    take = 1'b1;
                end
            end
            default: begin
                if (!is_ws && r_pend) begin
                    n_alive = '0;
                    n_pend  = 1'b0;
                end
                if (prog_step >= 3'(FLAG_LEN)) begin
                    n_seen = 1'b1;
                    n_prog = 3'd0;
                end else begin
                    n_prog = prog_step;
                end
            end
        endcase
        // A word byte after embedded whitespace kills every verb
        if (take) begin
            if (r_pend) begin
                n_alive = '0;
                n_pend  = 1'b0;
            end else begin
                n_alive = r_alive & char_ok;
            end
            if (r_count != COUNT_MAX) begin
                n_count = r_count + 4'd1;
            end
        end
    end

    // Lowest-numbered live verb whose length equals the word length
    always_comb begin
        o_result = '0;
        for (int i = VERB_COUNT - 1; i >= 0; i--) begin
            if (n_alive[i] && (n_count == verb_len(3'(i)))) begin
                o_result.matched      = 1'b1;
                o_result.command_code = 3'(i);
                o_result.json_flag    = n_seen;
            end
        end
    end

    // State registers; cleared on reset and after the last byte of each message
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_phase <= PH_LEAD;
            r_alive <= '1;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_prog  <= '0;
            r_seen  <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_alive <= n_alive;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_prog  <= n_prog;
            r_seen  <= n_seen;
        end
    end

endmodule

// File: sv/cvm_checker.sv
// Port-level checks for the control verb matcher, bound to the top level.
module cvm_checker
    import cvm_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_matched,
    input logic [2:0] i_code,
    input logic       i_json
);

    // A pending result holds until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_matched) &&
        $stable(i_code) && $stable(i_json))
        else $error("result changed before transfer");

    // No match carries a zero code and no json flag
    a_nomatch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_matched |-> (i_code == 3'd0) && !i_json)
        else $error("unmatched result with nonzero fields");

    // Code stays within the verb table
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_code <= CODE_LAST)
        else $error("command code out of range");

    // Reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind control_verb_matcher cvm_checker u_cvm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_matched   (o_res.matched),
    .i_code      (o_res.command_code),
    .i_json      (o_res.json_flag)
);

// File: tb/control_verb_matcher_test.sv
// Self-checking testbench for control_verb_matcher: message stimulus, verb predictor, checks.
module control_verb_matcher_test;
    import cvm_pkg::*;

    localparam int BYTE_TARGET  = 1550;
    localparam int CALM_FROM    = 1300;   // no idling once this many bytes went through
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_TICKS = 6;

    // Predicts the verb result of each message and checks the block's results
    class verb_scoreboard;
        string      verb_word[VERB_COUNT];
        string      json_opt;
        logic [1:0] phase;
        logic [6:0] live_verbs;
        logic [3:0] word_len;
        logic       blank_pending;
        logic [2:0] json_pos;
        logic       json_hit;
        t_result    expected_q[$];
        int         errors;

        function new();
            verb_word = '{"start", "stop", "toggle", "dictate", "cancel", "status", "reload"};
            json_opt  = "--json";
            errors    = 0;
            clear();
        endfunction

        function void clear();
            phase         = PH_LEAD;
            live_verbs    = '1;
            word_len      = '0;
            blank_pending = 1'b0;
            json_pos      = '0;
            json_hit      = 1'b0;
        endfunction

        function bit is_blank(logic [7:0] c);
            return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
        endfunction

        // One byte of the command word: narrow the set of verbs still possible
        function void word_byte(logic [7:0] c);
            if (blank_pending) begin
                live_verbs    = '0;
                blank_pending = 1'b0;
            end else begin
                for (int i = 0; i < VERB_COUNT; i++) begin
                    if (!(int'(word_len) < verb_word[i].len() &&
                          8'(verb_word[i][word_len]) == c))
                        live_verbs[i] = 1'b0;
                end
            end
            if (word_len != COUNT_MAX)
                word_len = word_len + 4'd1;
        endfunction

        // Search for the json option after the word
        function void json_byte(logic [7:0] c);
            if (json_pos < FLAG_LEN && c == 8'(json_opt[json_pos])) begin
                json_pos = json_pos + 3'd1;
            end else if (c == CH_DASH) begin
                json_pos = (json_pos == 3'd2) ? 3'd2 : 3'd1;
            end else begin
                json_pos = '0;
            end
            if (json_pos >= FLAG_LEN) begin
                json_hit = 1'b1;
                json_pos = '0;
            end
        endfunction

        // Accepted input transfer
        function void note_byte(logic [7:0] c, logic last);
            t_result r;
            case (phase)
                PH_LEAD: begin
                    if (c != CH_SPACE && c != CH_TAB) begin
                        phase = PH_WORD;
                        if (c == CH_CR || c == CH_LF)
                            blank_pending = 1'b1;
                        else
                            word_byte(c);
                    end
                end
                PH_WORD: begin
                    if (c == CH_SPACE)
                        phase = PH_AFTER;
                    else if (c == CH_TAB || c == CH_CR || c == CH_LF)
                        blank_pending = 1'b1;
                    else
                        word_byte(c);
                end
                default: begin
                    if (!is_blank(c) && blank_pending) begin
                        live_verbs    = '0;
                        blank_pending = 1'b0;
                    end
                    json_byte(c);
                end
            endcase
            if (last) begin
                r = '0;
                for (int i = 0; i < VERB_COUNT; i++) begin
                    if (!r.matched && live_verbs[i] && int'(word_len) == verb_word[i].len()) begin
                        r.matched      = 1'b1;
                        r.command_code = 3'(i);
                        r.json_flag    = json_hit;
                    end
                end
                expected_q.push_back(r);
                clear();
            end
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        // Accepted output transfer
        task check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                report($sformatf("result %b/%0d/%b with no message pending",
                                 got.matched, got.command_code, got.json_flag));
            end else begin
                want = expected_q.pop_front();
                if (got.matched !== want.matched)
                    report($sformatf("matched %b, want %b", got.matched, want.matched));
                if (got.command_code !== want.command_code)
                    report($sformatf("command_code %0d, want %0d",
                                     got.command_code, want.command_code));
                if (got.json_flag !== want.json_flag)
                    report($sformatf("json_flag %b, want %b", got.json_flag, want.json_flag));
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    cvm_in_if  in_ch();
    cvm_out_if out_ch();

    control_verb_matcher u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_msg   (in_ch),
        .o_res   (out_ch)
    );

    verb_scoreboard sb = new();

    string      verb_list[VERB_COUNT] = '{"start", "stop", "toggle", "dictate",
                                          "cancel", "status", "reload"};
    logic [7:0] msg_q[$];
    int         bytes_sent;
    int         cycle_count;
    bit         idle_on;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side: check each transfer, stall in random bursts
    initial begin
        int stall_left;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
                sb.check_result('{out_ch.matched, out_ch.command_code, out_ch.json_flag});
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 14) - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
            @(posedge i_clk);
        end
    end

    // Message building
    task automatic add_text(string s);
        for (int k = 0; k < s.len(); k++)
            msg_q.push_back(8'(s[k]));
    endtask

    function automatic logic [7:0] any_blank();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    function automatic logic [7:0] inner_blank();
        case ($urandom_range(0, 2))
            0:       return CH_TAB;
            1:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    // One byte transfer, after an optional gap
    task automatic send_byte(logic [7:0] c, logic last);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.char_byte <= c;
        in_ch.last_byte <= last;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        sb.note_byte(c, last);
        bytes_sent++;
    endtask

    task automatic send_message();
        for (int k = 0; k < msg_q.size(); k++)
            send_byte(msg_q[k], k == msg_q.size() - 1);
        msg_q.delete();
    endtask

    // Word for a well-formed message: a verb, sometimes slightly damaged
    task automatic add_verb_word();
        string w;
        int    pos;
        w = verb_list[$urandom_range(0, VERB_COUNT - 1)];
        pos = $urandom_range(0, w.len() - 1);
        case ($urandom_range(0, 9))
            0: w[pos] = 8'($urandom_range(8'h21, 8'h7e));
            1: w = w.substr(0, w.len() - 2);
            2: w = {w, "s"};
            default: ;
        endcase
        for (int k = 0; k < w.len(); k++) begin
            // tab, CR or LF inside the word
            if (k > 0 && $urandom_range(0, 29) == 0)
                msg_q.push_back(inner_blank());
            msg_q.push_back(8'(w[k]));
        end
    endtask

    // Argument after the word
    task automatic add_arg();
        case ($urandom_range(0, 9))
            0, 1, 2: add_text("--json");
            3:       add_text("--js");
            4:       add_text("---json");
            5:       add_text("--jso--json");
            6:       add_text("-");
            7:       add_text("json");
            8: begin
                repeat ($urandom_range(1, 6)) msg_q.push_back(8'($urandom_range(8'h61, 8'h7a)));
            end
            default: msg_q.push_back(8'($urandom_range(0, 255)));
        endcase
    endtask

    task automatic build_random_message();
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 65) begin
            repeat ($urandom_range(0, 2))
                msg_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
            add_verb_word();
            if ($urandom_range(0, 5) == 0)
                msg_q.push_back(inner_blank());
            repeat ($urandom_range(0, 3)) begin
                msg_q.push_back(CH_SPACE);
                add_arg();
            end
            repeat ($urandom_range(0, 3)) msg_q.push_back(any_blank());
        end else if (kind < 82) begin
            case ($urandom_range(0, 3))
                // whitespace only
                0: repeat ($urandom_range(1, 4)) msg_q.push_back(any_blank());
                // word opening with CR or LF
                1: begin
                    msg_q.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
                    add_text(verb_list[$urandom_range(0, VERB_COUNT - 1)]);
                end
                // long word
                2: begin
                    add_text(verb_list[$urandom_range(0, VERB_COUNT - 1)]);
                    repeat ($urandom_range(3, 12)) msg_q.push_back(8'($urandom_range(8'h61, 8'h7a)));
                    if ($urandom_range(0, 1)) add_text(" --json");
                end
                // blank byte after the word, then more text
                default: begin
                    add_text(verb_list[$urandom_range(0, VERB_COUNT - 1)]);
                    msg_q.push_back(inner_blank());
                    if ($urandom_range(0, 1)) msg_q.push_back(CH_SPACE);
                    add_arg();
                end
            endcase
        end else begin
            repeat ($urandom_range(1, 12)) msg_q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // Main sequence
    initial begin
        bytes_sent = 0;
        idle_on    = 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.char_byte <= '0;
        in_ch.last_byte <= 1'b0;
        i_rst_n <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: json option with trimmed tail
        msg_q.push_back(CH_TAB);
        add_text("stop --json");
        msg_q.push_back(CH_CR);
        msg_q.push_back(CH_LF);
        send_message();
        // whitespace only
        msg_q.push_back(CH_SPACE);
        msg_q.push_back(CH_LF);
        send_message();
        // word opening with CR
        msg_q.push_back(CH_CR);
        add_text("stop");
        send_message();
        // tab inside the word, then more word
        add_text("sto");
        msg_q.push_back(CH_TAB);
        add_text("p");
        send_message();
        // byte extremes
        msg_q.push_back(8'h00);
        msg_q.push_back(8'hFF);
        send_message();
        // every verb, one with a trailing tab
        for (int v = 0; v < VERB_COUNT; v++) begin
            add_text(verb_list[v]);
            if (v == 2) msg_q.push_back(CH_TAB);
            send_message();
        end

        // Random messages
        while (bytes_sent < BYTE_TARGET) begin
            idle_on = (bytes_sent < CALM_FROM) && ($urandom_range(0, 3) != 0);
            build_random_message();
            send_message();
        end
        in_ch.valid <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: sim.f
sv/cvm_pkg.sv
sv/cvm_in_if.sv
sv/cvm_out_if.sv
sv/cvm_parser.sv
sv/control_verb_matcher.sv
sv/cvm_checker.sv
tb/control_verb_matcher_test.sv
